@@ sv/stma_pkg.sv @@
`timescale 1ns / 1ps

package stma_pkg;

  localparam int MAX_TERMS  = 16;
  localparam int INDEX_BITS = 10;
  localparam int PTR_W      = $clog2(MAX_TERMS);
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int VAL_W      = 16;
  localparam int SUM_W      = VAL_W + 1;
  localparam int DIM_W      = 11;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

  typedef struct packed {
    logic [INDEX_BITS-1:0]   row;
    logic [INDEX_BITS-1:0]   col;
    logic signed [VAL_W-1:0] value;
  } triplet_t;

  typedef struct packed {
    logic                    take_a;
    logic                    take_b;
    logic [INDEX_BITS-1:0]   row;
    logic [INDEX_BITS-1:0]   col;
    logic signed [SUM_W-1:0] value;
  } merge_res_t;

endpackage

@@ sv/stma_ifs.sv @@
`timescale 1ns / 1ps

interface stma_in_if import stma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [INDEX_BITS-1:0]   term_row;
  logic [INDEX_BITS-1:0]   term_col;
  logic signed [VAL_W-1:0] term_value;

  modport source (output valid, command, term_row, term_col, term_value, input ready);
  modport sink (input valid, command, term_row, term_col, term_value, output ready);
endinterface

interface stma_out_if import stma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [INDEX_BITS-1:0]   out_row;
  logic [INDEX_BITS-1:0]   out_col;
  logic signed [SUM_W-1:0] out_value;
  logic                    has_term;
  logic [STAT_W-1:0]       status;
  logic                    last_result;

  modport source (output valid, out_row, out_col, out_value, has_term, status, last_result,
                  input ready);
  modport sink (input valid, out_row, out_col, out_value, has_term, status, last_result,
                output ready);
endinterface

interface stma_cfg_if import stma_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/stma_merge_unit.sv @@
`timescale 1ns / 1ps

// compares the two list heads and forms the next output term
module stma_merge_unit import stma_pkg::*; (
  input  triplet_t   head_a,
  input  triplet_t   head_b,
  input  logic       a_valid,
  input  logic       b_valid,
  output merge_res_t res
);

  logic take_a;
  logic take_b;
  logic signed [SUM_W-1:0] val_a;
  logic signed [SUM_W-1:0] val_b;

  always_comb begin
    if (a_valid && b_valid) begin
      if (head_a.row == head_b.row) begin
        take_a = head_a.col <= head_b.col;
        take_b = head_a.col >= head_b.col;
      end else begin
        take_a = head_a.row < head_b.row;
        take_b = !take_a;
      end
    end else begin
      take_a = a_valid;
      take_b = b_valid;
    end
  end

  assign val_a = take_a ? SUM_W'(head_a.value) : '0;
  assign val_b = take_b ? SUM_W'(head_b.value) : '0;

  assign res.take_a = take_a;
  assign res.take_b = take_b;
  assign res.row    = take_a ? head_a.row : head_b.row;
  assign res.col    = take_a ? head_a.col : head_b.col;
  assign res.value  = val_a + val_b;

endmodule

@@ sv/sparse_triplet_matrix_add.sv @@
`timescale 1ns / 1ps
// load commands are taken back to back; ready stays high while idle
// a start runs the merge through one shared compare/add unit, one result per cycle unless out
// stalls: count_a + count_b results at most (one if a status or empty result); the first is
// registered once in merge state; input ready is low until the last result is registered
// reset empties both lists, clears the overflow flag and sets all dimensions to 1;
// list contents are not cleared
module sparse_triplet_matrix_add import stma_pkg::*; (
  input logic       clk,
  input logic       rst,
  stma_in_if.sink   in,
  stma_out_if.source out,
  stma_cfg_if.sink  cfg
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_MERGE = 1'b1;

  logic state;

  triplet_t list_a [MAX_TERMS];
  triplet_t list_b [MAX_TERMS];
  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic [CNT_W-1:0] ptr_a;
  logic [CNT_W-1:0] ptr_b;
  logic [CNT_W-1:0] ptr_a_next;
  logic [CNT_W-1:0] ptr_b_next;
  logic overflow_seen;

  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] cols_a;
  logic [DIM_W-1:0] rows_b;
  logic [DIM_W-1:0] cols_b;

  logic                    out_valid;
  logic [INDEX_BITS-1:0]   out_row;
  logic [INDEX_BITS-1:0]   out_col;
  logic signed [SUM_W-1:0] out_value;
  logic                    has_term;
  logic [STAT_W-1:0]       status;
  logic                    last_result;

  logic in_fire;
  logic slot_free;
  logic step;
  logic load_a;
  logic load_b;
  logic a_valid;
  logic b_valid;
  triplet_t head_a;
  triplet_t head_b;
  merge_res_t mres;

  logic                    emit_has;
  logic [STAT_W-1:0]       emit_status;
  logic [INDEX_BITS-1:0]   emit_row;
  logic [INDEX_BITS-1:0]   emit_col;
  logic signed [SUM_W-1:0] emit_value;
  logic                    emit_last;
  logic                    adv_a;
  logic                    adv_b;

  assign in.ready  = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign in_fire   = in.valid && in.ready;

  assign slot_free = !out_valid || out.ready;
  assign step      = (state == S_MERGE) && slot_free;

  assign load_a = in_fire && (in.command == CMD_LOAD_A) && (count_a != CNT_W'(MAX_TERMS));
  assign load_b = in_fire && (in.command == CMD_LOAD_B) && (count_b != CNT_W'(MAX_TERMS));

  assign a_valid = ptr_a < count_a;
  assign b_valid = ptr_b < count_b;
  assign head_a  = list_a[ptr_a[PTR_W-1:0]];
  assign head_b  = list_b[ptr_b[PTR_W-1:0]];

  stma_merge_unit u_merge (
    .head_a  (head_a),
    .head_b  (head_b),
    .a_valid (a_valid),
    .b_valid (b_valid),
    .res     (mres)
  );

  assign ptr_a_next = ptr_a + CNT_W'(adv_a);
  assign ptr_b_next = ptr_b + CNT_W'(adv_b);

  always_comb begin
    emit_has    = 1'b0;
    emit_status = STAT_OK;
    emit_row    = '0;
    emit_col    = '0;
    emit_value  = '0;
    emit_last   = 1'b1;
    adv_a       = 1'b0;
    adv_b       = 1'b0;
    priority if (overflow_seen) begin
      emit_status = STAT_OVERFLOW;
    end else if (rows_a != rows_b || cols_a != cols_b) begin
      emit_status = STAT_MISMATCH;
    end else if (a_valid || b_valid) begin
      emit_has   = 1'b1;
      emit_row   = mres.row;
      emit_col   = mres.col;
      emit_value = mres.value;
      adv_a      = mres.take_a;
      adv_b      = mres.take_b;
      emit_last  = (ptr_a_next >= count_a) && (ptr_b_next >= count_b);
    end else begin
      // both lists empty: single empty ok result
      emit_status = STAT_OK;
    end
  end

  // list storage, no reset
  always_ff @(posedge clk) begin
    if (load_a) begin
      list_a[count_a[PTR_W-1:0]] <= '{row: in.term_row, col: in.term_col,
                                      value: in.term_value};
    end
    if (load_b) begin
      list_b[count_b[PTR_W-1:0]] <= '{row: in.term_row, col: in.term_col,
                                      value: in.term_value};
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_row     <= emit_row;
      out_col     <= emit_col;
      out_value   <= emit_value;
      has_term    <= emit_has;
      status      <= emit_status;
      last_result <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      ptr_a         <= '0;
      ptr_b         <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      rows_a        <= DIM_W'(1);
      cols_a        <= DIM_W'(1);
      rows_b        <= DIM_W'(1);
      cols_b        <= DIM_W'(1);
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_ROWS_A: rows_a <= cfg.data;
          CFG_COLS_A: cols_a <= cfg.data;
          CFG_ROWS_B: rows_b <= cfg.data;
          CFG_COLS_B: cols_b <= cfg.data;
          default: ;
        endcase
      end

      if (step) begin
        out_valid <= 1'b1;
      end else if (out.valid && out.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in.command)
              CMD_LOAD_A: begin
                if (load_a) begin
                  count_a <= count_a + CNT_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              CMD_LOAD_B: begin
                if (load_b) begin
                  count_b <= count_b + CNT_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              CMD_START: begin
                state <= S_MERGE;
                ptr_a <= '0;
                ptr_b <= '0;
              end
              default: ;
            endcase
          end
        end
        S_MERGE: begin
          if (step) begin
            ptr_a     <= ptr_a_next;
            ptr_b     <= ptr_b_next;
            if (emit_last) begin
              state         <= S_IDLE;
              count_a       <= '0;
              count_b       <= '0;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out.valid       = out_valid;
  assign out.out_row     = out_row;
  assign out.out_col     = out_col;
  assign out.out_value   = out_value;
  assign out.has_term    = has_term;
  assign out.status      = status;
  assign out.last_result = last_result;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import stma_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES = 10;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 78;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [INDEX_BITS-1:0]   row;
    logic [INDEX_BITS-1:0]   col;
    logic signed [SUM_W-1:0] value;
    logic                    has_term;
    logic [STAT_W-1:0]       status;
    logic                    last_result;
  } sum_term_t;

  class sum_checker;
    triplet_t list_a[MAX_TERMS];
    triplet_t list_b[MAX_TERMS];
    int count_a;
    int count_b;
    bit overflow_seen;
    logic [DIM_W-1:0] dims[4];
    sum_term_t pending[$];
    int failures;
    int results_seen;
    int loads;
    int starts;
    int terms;
    int zero_sums;
    int empties;
    int overflows;
    int dim_errors;

    function new();
      foreach (dims[k]) dims[k] = 11'd1;
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      dims[idx] = val;
    endfunction

    // called on every input transfer; a start expands into the expected merge output
    function void note_input(logic [CMD_W-1:0] cmd, logic [INDEX_BITS-1:0] t_row,
                             logic [INDEX_BITS-1:0] t_col, logic signed [VAL_W-1:0] t_value);
      sum_term_t batch[$];
      sum_term_t r;
      triplet_t ta;
      triplet_t tb;
      logic signed [SUM_W-1:0] va;
      logic signed [SUM_W-1:0] vb;
      int i;
      int j;
      bit take_a;
      bit take_b;
      case (cmd)
        CMD_LOAD_A: begin
          loads++;
          if (count_a >= MAX_TERMS) overflow_seen = 1'b1;
          else begin
            list_a[count_a] = '{row: t_row, col: t_col, value: t_value};
            count_a++;
          end
        end
        CMD_LOAD_B: begin
          loads++;
          if (count_b >= MAX_TERMS) overflow_seen = 1'b1;
          else begin
            list_b[count_b] = '{row: t_row, col: t_col, value: t_value};
            count_b++;
          end
        end
        CMD_START: begin
          starts++;
          r = '0;
          r.last_result = 1'b1;
          if (overflow_seen) begin
            r.status = STAT_OVERFLOW;
            overflows++;
            batch.push_back(r);
          end else if (dims[CFG_ROWS_A] != dims[CFG_ROWS_B] ||
                       dims[CFG_COLS_A] != dims[CFG_COLS_B]) begin
            r.status = STAT_MISMATCH;
            dim_errors++;
            batch.push_back(r);
          end else begin
            i = 0;
            j = 0;
            while (i < count_a || j < count_b) begin
              if (i < count_a) ta = list_a[i];
              if (j < count_b) tb = list_b[j];
              if (i < count_a && j < count_b) begin
                if (ta.row == tb.row) begin
                  take_a = ta.col <= tb.col;
                  take_b = ta.col >= tb.col;
                end else begin
                  take_a = ta.row < tb.row;
                  take_b = !take_a;
                end
              end else begin
                take_a = i < count_a;
                take_b = !take_a;
              end
              va = ta.value;
              vb = tb.value;
              r = '0;
              r.has_term = 1'b1;
              r.status = STAT_OK;
              if (take_a) begin
                r.row = ta.row;
                r.col = ta.col;
              end else begin
                r.row = tb.row;
                r.col = tb.col;
              end
              if (take_a && take_b) begin
                r.value = va + vb;
                if (r.value == 0) zero_sums++;
                i++;
                j++;
              end else if (take_a) begin
                r.value = va;
                i++;
              end else begin
                r.value = vb;
                j++;
              end
              terms++;
              batch.push_back(r);
            end
            if (batch.size() == 0) begin
              r = '0;
              r.last_result = 1'b1;
              empties++;
              batch.push_back(r);
            end else begin
              r = batch.pop_back();
              r.last_result = 1'b1;
              batch.push_back(r);
            end
          end
          foreach (batch[k]) pending.push_back(batch[k]);
          count_a = 0;
          count_b = 0;
          overflow_seen = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(sum_term_t got);
      sum_term_t want;
      results_seen++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t unexpected result: row %0d col %0d value %0d term %0b status %0d last %0b",
                   $realtime, got.row, got.col, got.value, got.has_term, got.status,
                   got.last_result);
        return;
      end
      want = pending.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
          got.has_term !== want.has_term || got.status !== want.status ||
          got.last_result !== want.last_result) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t result mismatch", $realtime);
          $display("  expected: row %0d col %0d value %0d term %0b status %0d last %0b",
                   want.row, want.col, want.value, want.has_term, want.status,
                   want.last_result);
          $display("  actual:   row %0d col %0d value %0d term %0b status %0d last %0b",
                   got.row, got.col, got.value, got.has_term, got.status, got.last_result);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;
  sum_checker sb = new();

  stma_in_if in_ch();
  stma_out_if out_ch();
  stma_cfg_if cfg_ch();

  sparse_triplet_matrix_add DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rand_position(bit narrow);
    // narrow positions crowd a few rows so equal rows and equal positions are common
    if (narrow) return ($urandom_range(0, 3) << INDEX_BITS) | $urandom_range(0, 7);
    return $urandom_range(0, (1 << (2 * INDEX_BITS)) - 1);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return VAL_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_BITS-1:0] t_row,
                           input logic [INDEX_BITS-1:0] t_col,
                           input logic signed [VAL_W-1:0] t_value);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.term_row <= t_row;
    in_ch.term_col <= t_col;
    in_ch.term_value <= t_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, t_row, t_col, t_value);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // block is idle only once every expected result is back and the tail has passed
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                            input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [DIM_W-1:0] val[4];
    idx = '{CFG_ROWS_A, CFG_COLS_A, CFG_ROWS_B, CFG_COLS_B};
    val = '{ra, ca, rb, cb};
    foreach (idx[k]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data <= val[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      sb.set_dim(idx[k], val[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // one addition: two term lists loaded interleaved, then a start
  task automatic run_batch(input bit force_full);
    int keys_a[$];
    int keys_b[$];
    logic signed [VAL_W-1:0] vals_a[$];
    logic signed [VAL_W-1:0] vals_b[$];
    logic signed [VAL_W-1:0] v;
    int n_a;
    int n_b;
    int ia;
    int ib;
    int key;
    bit narrow;
    narrow = ($urandom_range(0, 2) == 0);
    n_a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_TERMS) : $urandom_range(0, 6);
    n_b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_TERMS) : $urandom_range(0, 6);
    if (force_full || $urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1)) n_a = MAX_TERMS + $urandom_range(1, 2);
      else n_b = MAX_TERMS + $urandom_range(1, 2);
    end
    repeat (n_a) keys_a.push_back(rand_position(narrow));
    repeat (n_b) begin
      if (keys_a.size() != 0 && $urandom_range(0, 1))
        keys_b.push_back(keys_a[$urandom_range(0, keys_a.size() - 1)]);
      else keys_b.push_back(rand_position(narrow));
    end
    // now and then an unsorted list
    if ($urandom_range(0, 9) == 0) keys_a.reverse();
    else keys_a.sort();
    if ($urandom_range(0, 9) == 0) keys_b.reverse();
    else keys_b.sort();
    foreach (keys_a[k]) vals_a.push_back(rand_value());
    foreach (keys_b[m]) begin
      v = rand_value();
      foreach (keys_a[k]) begin
        if (keys_a[k] == keys_b[m] && $urandom_range(0, 2) == 0) v = -vals_a[k];
      end
      vals_b.push_back(v);
    end
    ia = 0;
    ib = 0;
    while (ia < keys_a.size() || ib < keys_b.size()) begin
      if ($urandom_range(0, 19) == 0)
        send_item(CMD_UNUSED, INDEX_BITS'($urandom_range(0, 1023)),
                  INDEX_BITS'($urandom_range(0, 1023)), rand_value());
      if (ib >= keys_b.size() || (ia < keys_a.size() && $urandom_range(0, 1))) begin
        key = keys_a[ia];
        send_item(CMD_LOAD_A, key[19:10], key[9:0], vals_a[ia]);
        ia++;
      end else begin
        key = keys_b[ib];
        send_item(CMD_LOAD_B, key[19:10], key[9:0], vals_b[ib]);
        ib++;
      end
    end
    send_item(CMD_START, INDEX_BITS'($urandom_range(0, 1023)),
              INDEX_BITS'($urandom_range(0, 1023)), rand_value());
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    int stall_left;
    bit hold_taken;
    sum_term_t got;
    stall_left = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = '{row: out_ch.out_row, col: out_ch.out_col, value: out_ch.out_value,
                has_term: out_ch.has_term, status: out_ch.status,
                last_result: out_ch.last_result};
        sb.check_result(got);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results pending", idle_cycles,
                 sb.pending.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int phase_end;
    bit first;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_LOAD_A;
    in_ch.term_row <= '0;
    in_ch.term_col <= '0;
    in_ch.term_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_ROWS_A;
    cfg_ch.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // both lists empty
    send_item(CMD_START, 10'd0, 10'd0, 16'sd0);
    // extreme positions and values, sums at both ends of the range
    send_item(CMD_LOAD_A, 10'd0, 10'd0, 16'sh7FFF);
    send_item(CMD_LOAD_B, 10'd0, 10'd0, 16'sh7FFF);
    send_item(CMD_LOAD_B, 10'd0, 10'd5, -16'sd1);
    send_item(CMD_LOAD_A, 10'd1023, 10'd1023, 16'sh8000);
    send_item(CMD_LOAD_B, 10'd1023, 10'd1023, 16'sh8000);
    send_item(CMD_START, 10'd1023, 10'd1023, 16'shFFFF);
    // terms that cancel still come out
    send_item(CMD_LOAD_A, 10'd2, 10'd3, 16'sd5);
    send_item(CMD_LOAD_B, 10'd2, 10'd3, -16'sd5);
    send_item(CMD_START, 10'd0, 10'd0, 16'sd0);
    // equal rows, columns interleaved
    send_item(CMD_LOAD_A, 10'd4, 10'd1, 16'sd1);
    send_item(CMD_LOAD_B, 10'd4, 10'd5, 16'sd3);
    send_item(CMD_LOAD_A, 10'd4, 10'd9, 16'sd2);
    send_item(CMD_START, 10'd0, 10'd0, 16'sd0);
    // unused command is dropped, then a single term
    send_item(CMD_UNUSED, 10'd7, 10'd7, 16'sd9);
    send_item(CMD_LOAD_A, 10'd7, 10'd7, 16'sd7);
    send_item(CMD_START, 10'd0, 10'd0, 16'sd0);
    // unsorted list
    send_item(CMD_LOAD_A, 10'd9, 10'd0, 16'sd1);
    send_item(CMD_LOAD_A, 10'd1, 10'd0, 16'sd2);
    send_item(CMD_LOAD_B, 10'd5, 10'd0, 16'sd3);
    send_item(CMD_START, 10'd0, 10'd0, 16'sd0);

    for (int p = 1; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        1: write_dims(11'd1024, 11'd1024, 11'd1024, 11'd1024);
        2: write_dims(11'd1024, 11'd1023, 11'd1024, 11'd1024);
        3: write_dims(11'd1, 11'd1024, 11'd1, 11'd1024);
        4: write_dims(11'd1023, 11'd1, 11'd1, 11'd1);
        default: write_dims(11'd513, 11'd700, 11'd513, 11'd700);
      endcase
      if (p == 1) hold_req = 1'b1;
      if (p == NUM_PHASES - 1) calm = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      first = 1'b1;
      while (items_sent < phase_end) begin
        // overflow first on a matching and on a mismatching setting
        run_batch(first && (p == 1 || p == 2));
        first = 1'b0;
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("covered %0d loads over %0d additions: %0d terms out, %0d cancelled, %0d empty",
             sb.loads, sb.starts, sb.terms, sb.zero_sums, sb.empties);
    $display("status results: %0d overflow, %0d dimension mismatch; %0d results, %0d failures",
             sb.overflows, sb.dim_errors, sb.results_seen, sb.failures);
    if (sb.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
